// ----- rtl/pixel_blend_with_modes_unit_defines.svh -----
// Assertion macros for the pixel blend unit.
// Included by the top level; no other dependencies.
`ifndef PIXEL_BLEND_WITH_MODES_UNIT_DEFINES_SVH
`define PIXEL_BLEND_WITH_MODES_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pixel blend assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PBM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pixel blend assertion failed");

`endif

// ----- rtl/pbm_pkg.sv -----
// Shared types, constants and arithmetic helpers of the pixel blend unit.
// No dependencies; used by every module of the block.
package pbm_pkg;

    localparam int NUM_STAGES = 6;
    localparam int SOFT_D_W   = 22;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_MULTIPLY = 2'd1,
        MODE_SCREEN   = 2'd2,
        MODE_SOFT     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_BLEND_MODE  = 2'd0,
        CFG_OPACITY     = 2'd1,
        CFG_MASK_ENABLE = 2'd2
    } cfg_index_t;

    localparam mode_t       BLEND_MODE_RESET  = MODE_NORMAL;
    localparam logic [16:0] OPACITY_RESET     = ONE_Q16;
    localparam logic        MASK_ENABLE_RESET = 1'b0;

    // Stage enables and the settled configuration, fanned out to every lane.
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        mode_t                 mode;
        logic [16:0]           opacity;
        logic                  mask_enable;
    } pbm_ctrl_t;

    typedef logic [SOFT_D_W-1:0] soft_d_rom_t [256];

    // Exact floor(x/255) by reciprocal multiplication, for three dividend widths.
    function automatic logic [8:0] div255_16(input logic [15:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'd32897;
        return p[31:23];
    endfunction

    function automatic logic [16:0] div255_24(input logic [23:0] x);
        logic [48:0] p;
        p = 49'(x) * 49'd16843010;
        return p[48:32];
    endfunction

    function automatic logic [23:0] div255_31(input logic [30:0] x);
        logic [62:0] p;
        p = 63'(x) * 63'd2155905153;
        return p[62:39];
    endfunction

    // Soft light bright branch: max(0, round(sqrt(b/255)*2^16)*255 - b*2^16).
    function automatic soft_d_rom_t build_soft_d_rom();
        soft_d_rom_t rom;
        logic [63:0] w;
        logic [63:0] res;
        logic [63:0] probe;
        logic [63:0] r;
        logic [63:0] scaled;
        logic [63:0] base;
        for (int b = 0; b < 256; b++) begin
            w   = (64'(b) << 34) / 64'd255;
            res = 64'd0;
            for (int i = 18; i >= 0; i--) begin
                probe = res | (64'd1 << i);
                if (probe * probe <= w) begin
                    res = probe;
                end
            end
            r      = (res + 64'd1) >> 1;
            scaled = r * 64'd255;
            base   = 64'(b) << 16;
            rom[b] = (scaled > base) ? SOFT_D_W'(scaled - base) : '0;
        end
        return rom;
    endfunction

    localparam soft_d_rom_t SOFT_D_ROM = build_soft_d_rom();

endpackage

// ----- rtl/pbm_opacity.sv -----
// Effective opacity path: saturates the global opacity and scales it by the mask.
// Depends on pbm_pkg; its output lines up with the final mix stage of the lanes.
module pbm_opacity (
    input  logic              aclk,
    input  pbm_pkg::pbm_ctrl_t ctrl,
    input  logic [7:0]        mask_value,
    output logic [16:0]       op_out
);

    logic [16:0] opc_next;
    logic [23:0] om_next;
    logic [16:0] div_q;
    logic [16:0] op1_next;

    logic [16:0] opc0_reg;
    logic [23:0] om0_reg;
    logic [16:0] op1_reg;
    logic [16:0] op2_reg;
    logic [16:0] op3_reg;
    logic [16:0] op4_reg;

    always_comb begin
        opc_next = (ctrl.opacity > pbm_pkg::ONE_Q16) ? pbm_pkg::ONE_Q16 : ctrl.opacity;
        om_next  = 24'(opc_next) * 24'(mask_value);
        div_q    = pbm_pkg::div255_24(om0_reg);
        op1_next = ctrl.mask_enable ? div_q : opc0_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[0]) begin
            opc0_reg <= opc_next;
            om0_reg  <= om_next;
        end
        if (ctrl.en[1]) begin
            op1_reg <= op1_next;
        end
        if (ctrl.en[2]) begin
            op2_reg <= op1_reg;
        end
        if (ctrl.en[3]) begin
            op3_reg <= op2_reg;
        end
        if (ctrl.en[4]) begin
            op4_reg <= op3_reg;
        end
    end

    assign op_out = op4_reg;

endmodule

// ----- rtl/pbm_lane.sv -----
// One colour channel of the blend pipeline: mode blend, soft light and opacity mix.
// Depends on pbm_pkg for the control struct, the division helpers and the ROM.
module pbm_lane (
    input  logic              aclk,
    input  pbm_pkg::pbm_ctrl_t ctrl,
    input  logic [7:0]        base_in,
    input  logic [7:0]        overlay_in,
    input  logic [16:0]       op_in,
    output logic [7:0]        out_chan
);

    // Stage 0 operands.
    logic [7:0]  mul_a;
    logic [7:0]  mul_c;
    logic [15:0] m1_next;
    logic [13:0] bb_next;
    logic [7:0]  f_next;
    logic        dark_next;
    logic [pbm_pkg::SOFT_D_W-1:0] d_next;

    logic [7:0]  b0_reg;
    logic [7:0]  s0_reg;
    logic [15:0] m1_reg;
    logic [13:0] bb_reg;
    logic [7:0]  f_reg;
    logic        dark0_reg;
    logic [pbm_pkg::SOFT_D_W-1:0] d_reg;

    // Stage 1.
    logic [8:0]  q255;
    logic [7:0]  simple_next;
    logic [21:0] opnd;
    logic [29:0] w_next;

    logic [7:0]  b1_reg;
    logic        dark1_reg;
    logic [7:0]  simple1_reg;
    logic [29:0] w_reg;

    // Stage 2.
    logic [30:0] x31;
    logic [23:0] y_next;

    logic [7:0]  b2_reg;
    logic        dark2_reg;
    logic [7:0]  simple2_reg;
    logic [21:0] prod2_reg;
    logic [23:0] y_reg;

    // Stage 3.
    logic [16:0] z_q;
    logic [21:0] corr_next;

    logic [7:0]  b3_reg;
    logic        dark3_reg;
    logic [7:0]  simple3_reg;
    logic [21:0] prod3_reg;
    logic [21:0] corr_reg;

    // Stage 4.
    logic signed [25:0] q_val;
    logic signed [25:0] qr;
    logic [7:0]  soft_val;
    logic [7:0]  blended;
    logic signed [8:0] diff_next;

    logic [7:0]  b4_reg;
    logic signed [8:0] diff_reg;

    // Stage 5.
    logic signed [17:0] op_s;
    logic signed [26:0] prod_mix;
    logic signed [27:0] sum_mix;
    logic [7:0]  out_next;
    logic [7:0]  out_reg;

    always_comb begin
        // Multiply and screen share one 8x8 product on inverted operands.
        mul_a     = (ctrl.mode == pbm_pkg::MODE_SCREEN) ? ~base_in : base_in;
        mul_c     = (ctrl.mode == pbm_pkg::MODE_SCREEN) ? ~overlay_in : overlay_in;
        m1_next   = 16'(mul_a) * 16'(mul_c);
        bb_next   = 14'(16'(base_in) * {8'd0, ~base_in});
        dark_next = ~overlay_in[7];
        // Dark: 255 - 2s; bright: 2s - 255.
        f_next    = dark_next ? ~{overlay_in[6:0], 1'b0} : {overlay_in[6:0], 1'b1};
        d_next    = pbm_pkg::SOFT_D_ROM[base_in];
    end

    always_comb begin
        q255 = pbm_pkg::div255_16(m1_reg);
        case (ctrl.mode)
            pbm_pkg::MODE_MULTIPLY: simple_next = q255[7:0];
            pbm_pkg::MODE_SCREEN:   simple_next = 8'd255 - q255[7:0];
            default:                simple_next = s0_reg;
        endcase
        opnd   = dark0_reg ? 22'(bb_reg) : d_reg;
        w_next = 30'(f_reg) * 30'(opnd);
    end

    always_comb begin
        // floor(p*65536/65025) = p + floor(p*511/65025) on the dark branch.
        x31    = dark1_reg ? (31'({w_reg[21:0], 9'b0}) - 31'(w_reg[21:0])) : 31'(w_reg);
        y_next = pbm_pkg::div255_31(x31);
    end

    always_comb begin
        z_q       = pbm_pkg::div255_24(y_reg);
        corr_next = dark2_reg ? 22'(z_q) : y_reg[21:0];
    end

    always_comb begin
        if (dark3_reg) begin
            q_val = $signed(26'({b3_reg, 16'b0})) - $signed(26'(prod3_reg))
                    - $signed(26'(corr_reg));
        end else begin
            q_val = $signed(26'({b3_reg, 16'b0})) + $signed(26'(corr_reg));
        end
        qr = q_val + 26'sd32768;
        if (q_val[25]) begin
            soft_val = 8'd0;
        end else if (qr[25] || qr[24]) begin
            soft_val = 8'd255;
        end else begin
            soft_val = qr[23:16];
        end
        blended   = (ctrl.mode == pbm_pkg::MODE_SOFT) ? soft_val : simple3_reg;
        diff_next = $signed({1'b0, blended}) - $signed({1'b0, b3_reg});
    end

    always_comb begin
        // b*(1-op) + blended*op is formed as b + (blended - b)*op.
        op_s     = $signed({1'b0, op_in});
        prod_mix = diff_reg * op_s;
        sum_mix  = $signed({4'b0, b4_reg, 16'b0}) + 28'(prod_mix) + 28'sd32768;
        if (sum_mix[27]) begin
            out_next = 8'd0;
        end else if (|sum_mix[26:24]) begin
            out_next = 8'd255;
        end else begin
            out_next = sum_mix[23:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[0]) begin
            b0_reg    <= base_in;
            s0_reg    <= overlay_in;
            m1_reg    <= m1_next;
            bb_reg    <= bb_next;
            f_reg     <= f_next;
            dark0_reg <= dark_next;
            d_reg     <= d_next;
        end
        if (ctrl.en[1]) begin
            b1_reg      <= b0_reg;
            dark1_reg   <= dark0_reg;
            simple1_reg <= simple_next;
            w_reg       <= w_next;
        end
        if (ctrl.en[2]) begin
            b2_reg      <= b1_reg;
            dark2_reg   <= dark1_reg;
            simple2_reg <= simple1_reg;
            prod2_reg   <= w_reg[21:0];
            y_reg       <= y_next;
        end
        if (ctrl.en[3]) begin
            b3_reg      <= b2_reg;
            dark3_reg   <= dark2_reg;
            simple3_reg <= simple2_reg;
            prod3_reg   <= prod2_reg;
            corr_reg    <= corr_next;
        end
        if (ctrl.en[4]) begin
            b4_reg   <= b3_reg;
            diff_reg <= diff_next;
        end
        if (ctrl.en[5]) begin
            out_reg <= out_next;
        end
    end

    assign out_chan = out_reg;

endmodule

// ----- rtl/pixel_blend_with_modes_unit.sv -----
// Top level of the pixel blend unit: configuration registers, stage control and lanes.
// Depends on pbm_pkg, pbm_lane, pbm_opacity and the assertion macro header.
`include "pixel_blend_with_modes_unit_defines.svh"

// Blends one base RGBA pixel with one overlay RGB pixel per clock while the output is
// not stalled. Every word passes through six register stages, and the unit sustains
// one pixel per cycle while m_tready stays high. Each stage holds its own valid bit
// and advances whenever the stage after it is empty or moving, so a stall on the
// output fills bubbles before back-pressure reaches the input. Configuration writes
// take effect at once and are to be made only while no word is in flight.
module pixel_blend_with_modes_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // From bit 0: base_red, base_green, base_blue, base_alpha,
    // overlay_red, overlay_green, overlay_blue, mask_value.
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // From bit 0: out_red, out_green, out_blue, out_alpha.
    output logic [31:0] m_tdata
);

    localparam int NS = pbm_pkg::NUM_STAGES;

    pbm_pkg::mode_t   blend_mode_reg;
    logic [16:0]      opacity_reg;
    logic             mask_enable_reg;

    logic [NS-1:0]    valid_reg;
    logic [NS-1:0]    stage_en;
    logic [7:0]       alpha_reg [NS];

    pbm_pkg::pbm_ctrl_t ctrl;
    logic [16:0]      op_final;
    logic [7:0]       red_out;
    logic [7:0]       green_out;
    logic [7:0]       blue_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_mode_reg  <= pbm_pkg::BLEND_MODE_RESET;
            opacity_reg     <= pbm_pkg::OPACITY_RESET;
            mask_enable_reg <= pbm_pkg::MASK_ENABLE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pbm_pkg::CFG_BLEND_MODE:  blend_mode_reg  <= pbm_pkg::mode_t'(cfg_wdata[1:0]);
                pbm_pkg::CFG_OPACITY:     opacity_reg     <= cfg_wdata;
                pbm_pkg::CFG_MASK_ENABLE: mask_enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or its word moves on in the same cycle.
    always_comb begin
        stage_en[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++) begin
                if (stage_en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            alpha_reg[0] <= s_tdata[31:24];
        end
        for (int i = 1; i < NS; i++) begin
            if (stage_en[i]) begin
                alpha_reg[i] <= alpha_reg[i-1];
            end
        end
    end

    always_comb begin
        ctrl.en          = stage_en;
        ctrl.mode        = blend_mode_reg;
        ctrl.opacity     = opacity_reg;
        ctrl.mask_enable = mask_enable_reg;
    end

    pbm_opacity u_opacity (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .mask_value (s_tdata[63:56]),
        .op_out     (op_final)
    );

    pbm_lane u_lane_red (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .base_in    (s_tdata[7:0]),
        .overlay_in (s_tdata[39:32]),
        .op_in      (op_final),
        .out_chan   (red_out)
    );

    pbm_lane u_lane_green (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .base_in    (s_tdata[15:8]),
        .overlay_in (s_tdata[47:40]),
        .op_in      (op_final),
        .out_chan   (green_out)
    );

    pbm_lane u_lane_blue (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .base_in    (s_tdata[23:16]),
        .overlay_in (s_tdata[55:48]),
        .op_in      (op_final),
        .out_chan   (blue_out)
    );

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = {alpha_reg[NS-1], blue_out, green_out, red_out};

    // An accepted word must occupy the first stage on the next cycle.
    `PBM_ASSERT_NEXT(a_accept_fills_first, aclk, aresetn, s_tvalid && s_tready, valid_reg[0])
    // With every stage full and the output stalled, nothing more may be taken.
    `PBM_ASSERT_NOW(a_full_blocks_input, aclk, aresetn, (&valid_reg) && !m_tready, !s_tready)
    // An empty first stage is always ready to take a word.
    `PBM_ASSERT_NOW(a_empty_takes_word, aclk, aresetn, !valid_reg[0], s_tready)

endmodule
